@@ design/chained_hash_date_table_macros.svh @@
// assertion macros used by the chained hash date table datapath
// no dependencies; include once per module that asserts
`ifndef CHAINED_HASH_DATE_TABLE_MACROS_SVH
`define CHAINED_HASH_DATE_TABLE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHDT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CHDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/chdt_pkg.sv @@
// shared types for the chained hash date table: payload structs, codes,
// controller states and the command/status bundles; no dependencies
`timescale 1ns / 1ps

package chdt_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_UPDATE = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      op_type             func;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [13:0]        year;
      logic signed [15:0] temperature;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] found_temperature;
      logic [5:0]         bucket_index;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIGIT,
      S_MUL,
      S_MOD,
      S_HEAD,
      S_HWAIT,
      S_INS_NODE,
      S_INS_LINK,
      S_RD,
      S_CMP,
      S_UPD,
      S_DEL_LINK,
      S_DEL_FREE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       dig_step;
      logic       mod_mul;
      logic       mod_fin;
      logic       head_rd;
      logic       alloc;
      logic       ins_node;
      logic       ins_link;
      logic       walk_start;
      logic       node_rd;
      logic       found_cap;
      logic       walk_next;
      logic       upd;
      logic       del_link;
      logic       del_free;
      logic       set_status;
      status_type status_code;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type func;
      logic   dig_last;
      logic   pool_full;
      logic   cur_null;
      logic   match;
      logic   rsp_busy;
   } sts_type;

endpackage

@@ design/chdt_ctrl.sv @@
// controller state machine of the chained hash date table
// depends on chdt_pkg; drives commands into chdt_datapath
`timescale 1ns / 1ps

module chdt_ctrl
   import chdt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.status_code = ST_OK;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            cmd.dig_step = 1'b1;
            if (sts.dig_last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mod_mul = 1'b1;
            state_in = S_MOD;
         end
         S_MOD: begin
            cmd.mod_fin = 1'b1;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            if (sts.func == OP_INSERT) begin
               if (sts.pool_full) begin
                  cmd.set_status = 1'b1;
                  cmd.status_code = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  cmd.alloc = 1'b1;
                  state_in = S_INS_NODE;
               end
            end else begin
               cmd.walk_start = 1'b1;
               state_in = S_RD;
            end
         end
         S_INS_NODE: begin
            cmd.ins_node = 1'b1;
            state_in = S_INS_LINK;
         end
         S_INS_LINK: begin
            cmd.ins_link = 1'b1;
            state_in = S_DONE;
         end
         S_RD: begin
            if (sts.cur_null) begin
               cmd.set_status = 1'b1;
               cmd.status_code = ST_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               cmd.node_rd = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.match) begin
               cmd.found_cap = 1'b1;
               unique case (sts.func)
                  OP_UPDATE: state_in = S_UPD;
                  OP_DELETE: state_in = S_DEL_LINK;
                  default:   state_in = S_DONE;
               endcase
            end else begin
               cmd.walk_next = 1'b1;
               state_in = S_RD;
            end
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            state_in = S_DONE;
         end
         S_DEL_LINK: begin
            cmd.del_link = 1'b1;
            state_in = S_DEL_FREE;
         end
         S_DEL_FREE: begin
            cmd.del_free = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ design/chdt_datapath.sv @@
// datapath of the chained hash date table: date hash, chain head/tail
// memories, node pool memories, free list and result register; uses chdt_pkg
`timescale 1ns / 1ps

`include "chained_hash_date_table_macros.svh"

module chdt_datapath
   import chdt_pkg::*;
#(
   parameter int BUCKETS      = 11,
   parameter int POOL_ENTRIES = 2048
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  cmd_type cmd,
   output sts_type sts
);

   localparam int PW    = $clog2(POOL_ENTRIES);
   localparam int PTR_W = PW + 1;
   localparam int BW    = $clog2(BUCKETS);
   localparam int SH    = 20;
   localparam int RECIP = ((1 << SH) + BUCKETS - 1) / BUCKETS;
   localparam logic [PTR_W-1:0] NULL_PTR = {1'b1, {PW{1'b0}}};
   localparam logic [PTR_W-1:0] POOL_CNT = PTR_W'(POOL_ENTRIES);

   // ascii digit sum of a two-digit field, values below 32
   function automatic logic [9:0] digsum2(input logic [4:0] v);
      logic [1:0] tens;
      logic [4:0] ones;
      if (v >= 5'd30) tens = 2'd3;
      else if (v >= 5'd20) tens = 2'd2;
      else if (v >= 5'd10) tens = 2'd1;
      else tens = 2'd0;
      ones = v - 5'(tens) * 5'd10;
      return 10'd96 + 10'(tens) + 10'(ones);
   endfunction

   // request capture
   op_type             func_ff;
   logic [22:0]        key_ff;
   logic [15:0]        temp_in_ff;

   // hash
   logic [9:0]         sum_ff;
   logic [13:0]        year_ff;
   logic               year_hi_ff;
   logic [2:0]         dig_cnt_ff;
   logic [29:0]        prod_ff;
   logic [BW-1:0]      bucket_ff;
   logic [30:0]        yprod;
   logic [13:0]        yq;
   logic [3:0]         ydig;
   logic [9:0]         mq;

   // chain heads and tails
   logic [PTR_W-1:0]   head_mem [BUCKETS];
   logic [PTR_W-1:0]   tail_mem [BUCKETS];
   logic [BUCKETS-1:0] head_vld_ff;
   logic [BUCKETS-1:0] tail_vld_ff;
   logic [PTR_W-1:0]   head_q;
   logic [PTR_W-1:0]   tail_q;
   logic               head_v_q;
   logic               tail_v_q;
   logic [PTR_W-1:0]   head_rd;
   logic [PTR_W-1:0]   tail_rd;

   // node pool
   logic [22:0]        date_mem [POOL_ENTRIES];
   logic [15:0]        temp_mem [POOL_ENTRIES];
   logic [PTR_W-1:0]   next_mem [POOL_ENTRIES];
   logic [PTR_W-1:0]   prev_mem [POOL_ENTRIES];
   logic [22:0]        date_q;
   logic [15:0]        temp_q;
   logic [PTR_W-1:0]   next_q;
   logic [PTR_W-1:0]   prev_q;
   logic [PW-1:0]      rd_addr;
   logic               rd_en;

   logic [PTR_W-1:0]   free_ff;
   logic [PTR_W-1:0]   fresh_ff;
   logic [PTR_W-1:0]   cur_ff;

   // result
   status_type         status_ff;
   logic [15:0]        found_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // one decimal digit of the year per step, and the quotient for the bucket modulo
   always_comb begin
      yprod = 31'(year_ff) * 31'd52429;
      yq    = 14'(yprod >> 19);
      ydig  = 4'(year_ff - ((yq << 3) + (yq << 1)));
      mq    = prod_ff[SH +: 10];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= req_data.func;
         key_ff     <= {req_data.month, req_data.day, req_data.year};
         temp_in_ff <= req_data.temperature;
         sum_ff     <= 10'd94 + digsum2({1'b0, req_data.month}) + digsum2(req_data.day);
         year_ff    <= req_data.year;
         year_hi_ff <= req_data.year >= 14'd10000;
         dig_cnt_ff <= '0;
      end else if (cmd.dig_step) begin
         if (dig_cnt_ff != 3'd4 || year_hi_ff) begin
            sum_ff <= sum_ff + 10'd48 + 10'(ydig);
         end
         year_ff    <= yq;
         dig_cnt_ff <= dig_cnt_ff + 3'd1;
      end
      if (cmd.mod_mul) begin
         prod_ff <= 30'(sum_ff) * 30'(RECIP);
      end
      if (cmd.mod_fin) begin
         bucket_ff <= BW'(sum_ff - 10'(mq * 10'(BUCKETS)));
      end
   end

   // head/tail memories, registered read
   always_ff @(posedge clock) begin
      if (cmd.head_rd) begin
         head_q <= head_mem[bucket_ff];
         tail_q <= tail_mem[bucket_ff];
      end
      if (cmd.ins_link && tail_rd[PW]) begin
         head_mem[bucket_ff] <= cur_ff;
      end else if (cmd.del_link && prev_q[PW]) begin
         head_mem[bucket_ff] <= next_q;
      end
      if (cmd.ins_link) begin
         tail_mem[bucket_ff] <= cur_ff;
      end else if (cmd.del_link && next_q[PW]) begin
         tail_mem[bucket_ff] <= prev_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
         tail_vld_ff <= '0;
         head_v_q    <= 1'b0;
         tail_v_q    <= 1'b0;
      end else begin
         if (cmd.head_rd) begin
            head_v_q <= head_vld_ff[bucket_ff];
            tail_v_q <= tail_vld_ff[bucket_ff];
         end
         if ((cmd.ins_link && tail_rd[PW]) || (cmd.del_link && prev_q[PW])) begin
            head_vld_ff[bucket_ff] <= 1'b1;
         end
         if (cmd.ins_link || (cmd.del_link && next_q[PW])) begin
            tail_vld_ff[bucket_ff] <= 1'b1;
         end
      end
   end

   assign head_rd = head_v_q ? head_q : NULL_PTR;
   assign tail_rd = tail_v_q ? tail_q : NULL_PTR;

   // pool memories: one read port, one write port each
   assign rd_en   = cmd.head_rd || cmd.node_rd;
   assign rd_addr = cmd.head_rd ? free_ff[PW-1:0] : cur_ff[PW-1:0];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         date_q <= date_mem[rd_addr];
         temp_q <= temp_mem[rd_addr];
         next_q <= next_mem[rd_addr];
         prev_q <= prev_mem[rd_addr];
      end
      if (cmd.ins_node) begin
         date_mem[cur_ff[PW-1:0]] <= key_ff;
      end
      if (cmd.ins_node || cmd.upd) begin
         temp_mem[cur_ff[PW-1:0]] <= temp_in_ff;
      end
      if (cmd.ins_node) begin
         next_mem[cur_ff[PW-1:0]] <= NULL_PTR;
      end else if (cmd.ins_link && !tail_rd[PW]) begin
         next_mem[tail_rd[PW-1:0]] <= cur_ff;
      end else if (cmd.del_link && !prev_q[PW]) begin
         next_mem[prev_q[PW-1:0]] <= next_q;
      end else if (cmd.del_free) begin
         next_mem[cur_ff[PW-1:0]] <= free_ff;
      end
      if (cmd.ins_node) begin
         prev_mem[cur_ff[PW-1:0]] <= tail_rd;
      end else if (cmd.del_link && !next_q[PW]) begin
         prev_mem[next_q[PW-1:0]] <= prev_q;
      end
   end

   // free list and never-used count
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= NULL_PTR;
         fresh_ff <= '0;
      end else if (cmd.alloc) begin
         if (!free_ff[PW]) begin
            free_ff <= next_q;
         end else begin
            fresh_ff <= fresh_ff + 1'b1;
         end
      end else if (cmd.del_free) begin
         free_ff <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         cur_ff <= free_ff[PW] ? fresh_ff : free_ff;
      end else if (cmd.walk_start) begin
         cur_ff <= head_rd;
      end else if (cmd.walk_next) begin
         cur_ff <= next_q;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff <= ST_OK;
         found_ff  <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.found_cap) begin
            found_ff <= temp_q;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.status            <= status_ff;
         rsp_ff.found_temperature <= found_ff;
         rsp_ff.bucket_index      <= 6'(bucket_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sts.func      = func_ff;
      sts.dig_last  = dig_cnt_ff == 3'd4;
      sts.pool_full = free_ff[PW] && (fresh_ff == POOL_CNT);
      sts.cur_null  = cur_ff[PW];
      sts.match     = date_q == key_ff;
      sts.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   `CHDT_ASSERT_SAME(a_fresh_bound, clock, reset, 1'b1, fresh_ff <= POOL_CNT, "fresh count beyond pool")
   `CHDT_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.rsp_load, !rsp_valid_ff || rsp_ready, "result overwritten")
   `CHDT_ASSERT_NEXT(a_alloc_valid, clock, reset, cmd.alloc, !cur_ff[PW], "allocated null node")
   `CHDT_ASSERT_SAME(a_match_valid, clock, reset, cmd.found_cap, !cur_ff[PW], "match on null node")

endmodule

@@ design/chained_hash_date_table.sv @@
// chained hash date table: hash, then work on one bucket chain per request.
// an insert takes a node from the free list or the never-used pool and links
// it at the chain tail, or reports full; search/update/delete walk the chain
// from its head to the first matching key, else report not found. one request
// in flight: the next request is taken only after the previous result has
// entered the output register; reset empties chains, free list and pool
`timescale 1ns / 1ps

module chained_hash_date_table
   import chdt_pkg::*;
#(
   parameter int BUCKETS      = 11,
   parameter int POOL_ENTRIES = 2048
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   chdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   chdt_datapath #(
      .BUCKETS      (BUCKETS),
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

@@ test/chained_hash_date_table_test.sv @@
// testbench for the chained hash date table: directed and random insert, search,
// update, delete transfers checked by a behavioral table model; uses chdt_pkg
`timescale 1ns / 1ps

class date_table_board;
   localparam int NBUCK = 11;
   localparam int NPOOL = 2048;
   localparam int NIL   = -1;

   int          chain_head[NBUCK];
   int          chain_tail[NBUCK];
   logic [22:0] node_key[NPOOL];
   logic [15:0] node_temp[NPOOL];
   int          node_next[NPOOL];
   int          node_prev[NPOOL];
   int          free_head;
   int          fresh;
   chdt_pkg::rsp_type pending[$];
   int          errors;

   function new();
      for (int i = 0; i < NBUCK; i++) begin
         chain_head[i] = NIL;
         chain_tail[i] = NIL;
      end
      free_head = NIL;
      fresh = 0;
      errors = 0;
   endfunction

   function int digits2(int v);
      return 96 + (v / 10) % 10 + v % 10;
   endfunction

   function int bucket_of(int m, int d, int y);
      int s;
      int v;
      int nd;
      s = 94 + digits2(m) + digits2(d);
      nd = (y >= 10000) ? 5 : 4;
      v = y;
      for (int i = 0; i < nd; i++) begin
         s += 48 + v % 10;
         v /= 10;
      end
      return s % NBUCK;
   endfunction

   function int find_first(int b, logic [22:0] key);
      int n;
      n = chain_head[b];
      while (n != NIL) begin
         if (node_key[n] == key) return n;
         n = node_next[n];
      end
      return NIL;
   endfunction

   // apply one accepted request to the table and queue its result
   function void note_request(chdt_pkg::req_type r);
      chdt_pkg::rsp_type o;
      logic [22:0] key;
      int b;
      int n;
      int p;
      int q;
      key = {r.month, r.day, r.year};
      b = bucket_of(r.month, r.day, r.year);
      o.status = chdt_pkg::ST_OK;
      o.found_temperature = '0;
      o.bucket_index = 6'(b);
      if (r.func == chdt_pkg::OP_INSERT) begin
         if (free_head != NIL) begin
            n = free_head;
            free_head = node_next[n];
         end else if (fresh < NPOOL) begin
            n = fresh;
            fresh++;
         end else n = NIL;
         if (n == NIL) o.status = chdt_pkg::ST_FULL;
         else begin
            node_key[n] = key;
            node_temp[n] = r.temperature;
            node_next[n] = NIL;
            node_prev[n] = chain_tail[b];
            if (chain_tail[b] != NIL) node_next[chain_tail[b]] = n;
            else chain_head[b] = n;
            chain_tail[b] = n;
         end
      end else begin
         n = find_first(b, key);
         if (n == NIL) o.status = chdt_pkg::ST_NOT_FOUND;
         else begin
            o.found_temperature = node_temp[n];
            if (r.func == chdt_pkg::OP_UPDATE) node_temp[n] = r.temperature;
            else if (r.func == chdt_pkg::OP_DELETE) begin
               p = node_prev[n];
               q = node_next[n];
               if (p != NIL) node_next[p] = q;
               else chain_head[b] = q;
               if (q != NIL) node_prev[q] = p;
               else chain_tail[b] = p;
               node_next[n] = free_head;
               free_head = n;
            end
         end
      end
      pending.push_back(o);
   endfunction

   task report(string what);
      $display("error at %0t: %s", $time, what);
      errors++;
   endtask

   task check_result(chdt_pkg::rsp_type got);
      chdt_pkg::rsp_type want;
      if (pending.size() == 0) begin
         report("result with nothing expected");
         return;
      end
      want = pending.pop_front();
      if (got.status != want.status)
         report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.found_temperature != want.found_temperature)
         report($sformatf("temperature %0d, expected %0d",
                          got.found_temperature, want.found_temperature));
      if (got.bucket_index != want.bucket_index)
         report($sformatf("bucket %0d, expected %0d",
                          got.bucket_index, want.bucket_index));
   endtask
endclass

module chained_hash_date_table_test;
   import chdt_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   date_table_board board = new();
   bit      hold_rsp = 1'b0;
   logic [22:0] used_keys[$];

   chained_hash_date_table uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      int g;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   // back-to-back transfers keep valid high across the falling edge
   task automatic send(req_type r);
      req_valid = 1'b1;
      req_data = r;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_op(op_type f, int m, int d, int y, int t);
      req_type r;
      r.func = f;
      r.month = 4'(m);
      r.day = 5'(d);
      r.year = 14'(y);
      r.temperature = 16'(t);
      send(r);
      if (f == OP_INSERT && used_keys.size() < 200) used_keys.push_back({r.month, r.day, r.year});
   endtask

   task automatic idle_gap();
      int g;
      g = gap_len();
      repeat (g) @(negedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // random op on a key mostly from those inserted, or a small set if narrow
   task automatic random_op(bit narrow);
      req_type r;
      logic [22:0] k;
      int sel;
      r = req_type'($bits(req_type)'({$urandom, $urandom}));
      sel = $urandom_range(0, 99);
      if (sel < 35) r.func = OP_INSERT;
      else r.func = op_type'($urandom_range(1, 3));
      if (narrow) begin
         r.month = 4'($urandom_range(1, 2));
         r.day = 5'($urandom_range(1, 3));
         r.year = 14'($urandom_range(2000, 2003));
      end else if (used_keys.size() > 0 && sel >= 10 && $urandom_range(0, 9) < 7) begin
         k = used_keys[$urandom_range(0, used_keys.size() - 1)];
         {r.month, r.day, r.year} = k;
      end else if ($urandom_range(0, 3) != 0) begin
         r.month = 4'($urandom_range(1, 12));
         r.day = 5'($urandom_range(1, 31));
         r.year = 14'($urandom_range(1000, 9999));
      end
      if (r.func == OP_INSERT && used_keys.size() < 200)
         used_keys.push_back({r.month, r.day, r.year});
      send(r);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (3) @(negedge clock);

      // directed: field extremes, every operation, head/middle/tail deletes
      send_op(OP_SEARCH, 1, 1, 1000, 0);
      send_op(OP_INSERT, 12, 31, 9999, 32767);
      send_op(OP_INSERT, 0, 0, 0, -32768);
      send_op(OP_INSERT, 15, 31, 16383, -1);
      send_op(OP_SEARCH, 15, 31, 16383, 0);
      send_op(OP_UPDATE, 12, 31, 9999, 1234);
      send_op(OP_SEARCH, 12, 31, 9999, 0);
      send_op(OP_INSERT, 3, 4, 2020, 100);
      send_op(OP_INSERT, 3, 4, 2020, 200);
      send_op(OP_INSERT, 3, 4, 2020, 300);
      send_op(OP_DELETE, 3, 4, 2020, 0);
      send_op(OP_INSERT, 3, 4, 2020, 400);
      send_op(OP_DELETE, 3, 4, 2020, 0);
      send_op(OP_DELETE, 3, 4, 2020, 0);
      send_op(OP_SEARCH, 3, 4, 2020, 0);
      send_op(OP_DELETE, 3, 4, 2020, 0);
      send_op(OP_DELETE, 3, 4, 2020, 0);
      send_op(OP_UPDATE, 7, 7, 7777, 5);
      send_op(OP_DELETE, 0, 0, 0, 0);
      send_op(OP_SEARCH, 0, 0, 0, 0);

      // receiver holds off while the sender keeps pushing
      hold_rsp = 1'b1;
      for (int i = 0; i < 12; i++) random_op(1'b1);
      drain();

      for (int i = 0; i < 1030; i++) begin
         random_op(i % 200 < 40);
         idle_gap();
         if (i == 500) drain();
      end
      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("chained_hash_date_table: match");
      else
         $display("chained_hash_date_table: mismatch");
      $finish;
   end

   initial begin
      #100ms;
      $display("chained_hash_date_table: mismatch");
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+design
design/chdt_pkg.sv
design/chdt_ctrl.sv
design/chdt_datapath.sv
design/chained_hash_date_table.sv
test/chained_hash_date_table_test.sv
